// ===== design/sfir_pkg.sv =====
// Shared types and constants of the state feedback integral regulator.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package sfir_pkg;

	// register map, index = paddr[4:2]
	typedef enum logic [2:0] {
		REG_GAIN_CURRENT  = 3'd0,
		REG_GAIN_VOLTAGE  = 3'd1,
		REG_GAIN_INTEGRAL = 3'd2,
		REG_VOLTAGE_TGT   = 3'd3,
		REG_INTEG_STEP    = 3'd4
	} reg_idx_t;

	localparam int unsigned ADDR_W = 5;

	localparam logic signed [31:0] RST_GAIN_CURRENT  = 32'sd55630;
	localparam logic signed [31:0] RST_GAIN_VOLTAGE  = -32'sd46462;
	localparam logic signed [31:0] RST_GAIN_INTEGRAL = -32'sd103418066;
	localparam logic signed [15:0] RST_VOLTAGE_TGT   = 16'sd1536;
	localparam logic        [31:0] RST_INTEG_STEP    = 32'd42950;

	localparam int unsigned INTEG_W = 48;
	localparam int unsigned PROD_W  = 58;
	localparam int unsigned ACC_W   = 58;
	localparam int unsigned DUTY_W  = 17;

	// 1.0 in the Q.28 feedback sum
	localparam logic signed [ACC_W-1:0] ONE_Q28 = 58'sd268435456;
	localparam logic [29:0] DUTY_RND = 30'd2048;

	typedef struct packed {
		logic signed [31:0] gain_current;
		logic signed [31:0] gain_voltage;
		logic signed [31:0] gain_integral;
		logic signed [15:0] voltage_target;
		logic        [31:0] integration_step;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MERR,
		ST_INTEG,
		ST_MVOL,
		ST_MHI,
		ST_MLO,
		ST_SUM,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		MUL_ERR,
		MUL_CUR,
		MUL_VOL,
		MUL_HI,
		MUL_LO
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_ADD_SHR
	} acc_op_t;

	typedef struct packed {
		logic     capture;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     integ_upd;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic out_full;
		logic out_take;
	} status_t;

endpackage

`default_nettype wire

// ===== design/sfir_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on sfir_pkg for the register map, reset values and cfg_t.
`default_nettype none

module sfir_regs (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [sfir_pkg::ADDR_W-1:0] paddr,
	input  wire  [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output sfir_pkg::cfg_t              cfg
);

	sfir_pkg::cfg_t    cfg_q;
	sfir_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = sfir_pkg::reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_current     <= sfir_pkg::RST_GAIN_CURRENT;
			cfg_q.gain_voltage     <= sfir_pkg::RST_GAIN_VOLTAGE;
			cfg_q.gain_integral    <= sfir_pkg::RST_GAIN_INTEGRAL;
			cfg_q.voltage_target   <= sfir_pkg::RST_VOLTAGE_TGT;
			cfg_q.integration_step <= sfir_pkg::RST_INTEG_STEP;
		end else if (wr_en) begin
			unique case (idx)
				sfir_pkg::REG_GAIN_CURRENT:  cfg_q.gain_current     <= pwdata;
				sfir_pkg::REG_GAIN_VOLTAGE:  cfg_q.gain_voltage     <= pwdata;
				sfir_pkg::REG_GAIN_INTEGRAL: cfg_q.gain_integral    <= pwdata;
				sfir_pkg::REG_VOLTAGE_TGT:   cfg_q.voltage_target   <= pwdata[15:0];
				sfir_pkg::REG_INTEG_STEP:    cfg_q.integration_step <= pwdata;
				default: ;	// drop writes outside the map
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			sfir_pkg::REG_GAIN_CURRENT:  prdata = cfg_q.gain_current;
			sfir_pkg::REG_GAIN_VOLTAGE:  prdata = cfg_q.gain_voltage;
			sfir_pkg::REG_GAIN_INTEGRAL: prdata = cfg_q.gain_integral;
			sfir_pkg::REG_VOLTAGE_TGT:   prdata = {16'd0, cfg_q.voltage_target};
			sfir_pkg::REG_INTEG_STEP:    prdata = cfg_q.integration_step;
			default:                     prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/sfir_dp.sv =====
// Datapath: shared multiplier, integrator, feedback accumulator, output register.
// Depends on sfir_pkg; driven by commands from sfir_ctrl.
`default_nettype none

module sfir_dp (
	input  wire                          clk,
	input  wire                          arst_n,
	input  sfir_pkg::cfg_t               cfg,
	input  sfir_pkg::cmd_t               cmd,
	output sfir_pkg::status_t            status,
	input  wire  signed [15:0]           coil_current,
	input  wire  signed [15:0]           output_voltage,
	output logic [sfir_pkg::DUTY_W-1:0]  duty,
	output logic                         clamped,
	output logic                         out_valid,
	input  wire                          out_ready
);

	localparam int unsigned IW = sfir_pkg::INTEG_W;
	localparam int unsigned PW = sfir_pkg::PROD_W;
	localparam int unsigned AW = sfir_pkg::ACC_W;

	logic signed [15:0]    cur_q;
	logic signed [15:0]    vol_q;
	logic signed [16:0]    err_q;
	logic signed [IW-1:0]  integ_q;
	logic signed [PW-1:0]  prod_q;
	logic signed [AW-1:0]  acc_q;
	logic [sfir_pkg::DUTY_W-1:0] duty_q;
	logic                  flag_q;
	logic                  out_valid_q;

	logic signed [32:0]    mul_a;
	logic signed [32:0]    mul_b;
	logic signed [65:0]    mul_p;
	logic signed [49:0]    inc_rnd;
	logic signed [41:0]    inc;
	logic signed [IW:0]    integ_sum;
	logic signed [IW-1:0]  integ_sat;
	logic signed [AW-1:0]  s_val;
	logic [29:0]           rnd;
	logic [sfir_pkg::DUTY_W-1:0] duty_d;
	logic                  flag_d;

	// operand select for the shared multiplier
	always_comb begin
		unique case (cmd.mul_sel)
			sfir_pkg::MUL_ERR: begin
				mul_a = 33'(err_q);
				mul_b = $signed({1'b0, cfg.integration_step});
			end
			sfir_pkg::MUL_CUR: begin
				mul_a = 33'(cfg.gain_current);
				mul_b = 33'(cur_q);
			end
			sfir_pkg::MUL_VOL: begin
				mul_a = 33'(cfg.gain_voltage);
				mul_b = 33'(vol_q);
			end
			sfir_pkg::MUL_HI: begin
				mul_a = 33'(cfg.gain_integral);
				mul_b = 33'($signed(integ_q[IW-1:24]));
			end
			sfir_pkg::MUL_LO: begin
				mul_a = 33'(cfg.gain_integral);
				mul_b = $signed({9'd0, integ_q[23:0]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// round the Q18.32 increment to Q.24, ties toward +inf, then saturate
	assign inc_rnd   = prod_q[49:0] + 50'sd128;
	assign inc       = inc_rnd[49:8];
	assign integ_sum = (IW+1)'(integ_q) + (IW+1)'(inc);

	always_comb begin
		if (integ_sum[IW] != integ_sum[IW-1])
			integ_sat = integ_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
		else
			integ_sat = integ_sum[IW-1:0];
	end

	// duty from the negated sum
	assign s_val = -acc_q;
	assign rnd   = {1'b0, s_val[28:0]} + sfir_pkg::DUTY_RND;

	always_comb begin
		priority if (s_val > sfir_pkg::ONE_Q28) begin
			duty_d = 17'd65536;
			flag_d = 1'b1;
		end else if (s_val[AW-1]) begin
			duty_d = 17'd0;
			flag_d = 1'b1;
		end else begin
			duty_d = rnd[28:12];
			flag_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cur_q <= coil_current;
			vol_q <= output_voltage;
			err_q <= 17'(cfg.voltage_target) - 17'(output_voltage);
		end
		prod_q <= mul_p[PW-1:0];
		unique case (cmd.acc_op)
			sfir_pkg::ACC_HOLD:    acc_q <= acc_q;
			sfir_pkg::ACC_LOAD:    acc_q <= prod_q;
			sfir_pkg::ACC_ADD:     acc_q <= acc_q + prod_q;
			sfir_pkg::ACC_ADD_SHR: acc_q <= acc_q + (prod_q >>> 24);
			default:               acc_q <= acc_q;
		endcase
		if (cmd.out_load) begin
			duty_q <= duty_d;
			flag_q <= flag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.integ_upd)
				integ_q <= integ_sat;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign duty            = duty_q;
	assign clamped         = flag_q;
	assign out_valid       = out_valid_q;
	assign status.out_full = out_valid_q;
	assign status.out_take = out_ready;

	a_clamp_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && flag_q |-> duty_q == 17'd0 || duty_q == 17'd65536)
		else $error("clamped result with duty off the rails");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> duty_q <= 17'd65536)
		else $error("duty above 1.0");

endmodule

`default_nettype wire

// ===== design/sfir_ctrl.sv =====
// Controller: steps one sample through the shared multiplier sequence.
// Depends on sfir_pkg for state, command and status types.
`default_nettype none

module sfir_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  sfir_pkg::status_t  status,
	output sfir_pkg::cmd_t     cmd
);

	sfir_pkg::state_t state_q;
	sfir_pkg::state_t state_d;
	logic             out_free;

	assign out_free = !status.out_full || status.out_take;
	assign in_ready = (state_q == sfir_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sfir_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		unique case (state_q)
			sfir_pkg::ST_IDLE:  state_d = in_valid ? sfir_pkg::ST_MERR : sfir_pkg::ST_IDLE;
			sfir_pkg::ST_MERR:  state_d = sfir_pkg::ST_INTEG;
			sfir_pkg::ST_INTEG: state_d = sfir_pkg::ST_MVOL;
			sfir_pkg::ST_MVOL:  state_d = sfir_pkg::ST_MHI;
			sfir_pkg::ST_MHI:   state_d = sfir_pkg::ST_MLO;
			sfir_pkg::ST_MLO:   state_d = sfir_pkg::ST_SUM;
			sfir_pkg::ST_SUM:   state_d = sfir_pkg::ST_FIN;
			sfir_pkg::ST_FIN:   state_d = out_free ? sfir_pkg::ST_IDLE : sfir_pkg::ST_FIN;
			default:            state_d = sfir_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.capture   = 1'b0;
		cmd.mul_sel   = sfir_pkg::MUL_ERR;
		cmd.acc_op    = sfir_pkg::ACC_HOLD;
		cmd.integ_upd = 1'b0;
		cmd.out_load  = 1'b0;
		unique case (state_q)
			sfir_pkg::ST_IDLE:  cmd.capture = in_valid;
			sfir_pkg::ST_MERR:  cmd.mul_sel = sfir_pkg::MUL_ERR;
			sfir_pkg::ST_INTEG: begin
				cmd.mul_sel   = sfir_pkg::MUL_CUR;
				cmd.integ_upd = 1'b1;
			end
			sfir_pkg::ST_MVOL: begin
				cmd.mul_sel = sfir_pkg::MUL_VOL;
				cmd.acc_op  = sfir_pkg::ACC_LOAD;
			end
			sfir_pkg::ST_MHI: begin
				cmd.mul_sel = sfir_pkg::MUL_HI;
				cmd.acc_op  = sfir_pkg::ACC_ADD;
			end
			sfir_pkg::ST_MLO: begin
				cmd.mul_sel = sfir_pkg::MUL_LO;
				cmd.acc_op  = sfir_pkg::ACC_ADD;
			end
			sfir_pkg::ST_SUM:   cmd.acc_op = sfir_pkg::ACC_ADD_SHR;
			sfir_pkg::ST_FIN:   cmd.out_load = out_free;
			default: ;
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == sfir_pkg::ST_MERR)
		else $error("accepted sample did not start the sequence");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !status.out_full || status.out_take)
		else $error("output register overwritten before transfer");

	a_integ_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.integ_upd |=> !cmd.integ_upd)
		else $error("integrator updated twice for one sample");

endmodule

`default_nettype wire

// ===== design/state_feedback_integral_regulator.sv =====
// Top level of the state feedback regulator with integral action.
// Instantiates sfir_regs, sfir_ctrl and sfir_dp; types come from sfir_pkg.
//
// Channel   Direction  Handshake                  Payload
// s_*       in         s_tvalid / s_tready        tdata: coil_current, output_voltage
// m_*       out        m_tvalid / m_tready        tdata: duty; tuser: clamped
// APB       in/out     psel, penable, pready = 1  five config registers at 4*i
//
// Each item steps through accept, then five products through one shared
// 33x33 multiplier (error*step, then the three gains times current, voltage
// and the two halves of the integral), one final shift-add and the output load.
// The result waits in an output register; the next sample is accepted as soon
// as the sequence returns to idle, even if that result is still untaken.
// A stalled m_tready holds the final state until the output register is free.
// Reset clears the integral and the handshake state; no clearing pass needed.
`default_nettype none

module state_feedback_integral_regulator (
	input  wire         clk,
	input  wire         arst_n,
	// slave stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,	// [15:0] coil_current, [31:16] output_voltage
	// master stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,	// [16:0] duty, [23:17] zero
	output logic [0:0]  m_tuser,	// [0] clamped
	// configuration
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [sfir_pkg::ADDR_W-1:0] paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	sfir_pkg::cfg_t    cfg;
	sfir_pkg::cmd_t    cmd;
	sfir_pkg::status_t status;
	logic [sfir_pkg::DUTY_W-1:0] duty;
	logic                        clamped;

	sfir_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequence one sample at a time
	sfir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sfir_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.status         (status),
		.coil_current   ($signed(s_tdata[15:0])),
		.output_voltage ($signed(s_tdata[31:16])),
		.duty           (duty),
		.clamped        (clamped),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready)
	);

	// pad duty out to whole bytes
	assign m_tdata = {7'd0, duty};
	assign m_tuser = clamped;

endmodule

`default_nettype wire
